// ===== src/codde_pkg.sv =====
// Shared widths, reset values and control/status types for the clock offset
// and drift estimator. No dependencies; every other file imports this package.
`default_nettype none

package codde_pkg;

  localparam int TS_W    = 63;  // timestamp and round trip width
  localparam int OFS_W   = 64;  // signed offset width
  localparam int DRIFT_W = 48;  // drift width (ppm, fixed point)
  localparam int CNT_W   = 32;  // sample counter width
  localparam int CFG_W   = 17;  // smoothing weight register width
  localparam int QUO_W   = DRIFT_W;  // quotient bits kept by the divider

  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int DRIFT_FRAC_BITS_DEF  = 16;

  localparam logic [CFG_W-1:0] CFG_WEIGHT_RESET = 17'd58982;

  // ppm scale: 10^6 needs 20 bits; |offset delta| * 10^6 needs 84 bits
  localparam int               PPM_W     = 20;
  localparam logic [PPM_W-1:0] PPM_SCALE = 20'd1000000;
  localparam int               MAG_W     = OFS_W + 1;
  localparam int               SCALED_W  = 84;

  localparam logic [DRIFT_W-1:0] DRIFT_MAX = {1'b0, {(DRIFT_W-1){1'b1}}};
  localparam logic [DRIFT_W-1:0] DRIFT_MIN = {1'b1, {(DRIFT_W-1){1'b0}}};

  localparam logic [TS_W-1:0]  RTT_RESET = {TS_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic load;          // capture input beat
    logic clear;         // restore estimator reset state
    logic rtt;           // round trip
    logic half;          // send + rtt/2
    logic raw;           // raw offset
    logic mul_old;       // weight * old offset
    logic mul_raw;       // (1 - weight) * raw offset
    logic sum;           // blend sum
    logic update;        // commit sample to estimator state
    logic diff;          // offset delta and elapsed peer time
    logic mag;           // magnitude and sign of delta
    logic mul_lo;        // low half of delta * 10^6
    logic mul_hi;        // high half of delta * 10^6
    logic scale;         // combine partial products
    logic div_start;     // launch divider
    logic drift_commit;  // saturate and store drift
    logic emit;          // load result register
    logic emit_acc;      // accepted flag for the result
  } codde_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic rtt_ok;
    logic first;
    logic dt_pos;
    logic div_done;
  } codde_sts_t;

endpackage

`default_nettype wire

// ===== src/codde_chan_if.sv =====
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on codde_pkg for field widths.
`default_nettype none

interface codde_in_if import codde_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [TS_W-1:0] send_time_ns;
  logic [TS_W-1:0] peer_time_ns;
  logic [TS_W-1:0] recv_time_ns;

  modport source (output valid, op, send_time_ns, peer_time_ns, recv_time_ns,
                  input ready);
  modport sink   (input valid, op, send_time_ns, peer_time_ns, recv_time_ns,
                  output ready);
endinterface

interface codde_out_if import codde_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic                      valid_res;
  logic signed [OFS_W-1:0]   offset_ns;
  logic signed [OFS_W-1:0]   min_rtt_offset_ns;
  logic signed [DRIFT_W-1:0] drift_ppm_q16;
  logic [TS_W-1:0]           min_rtt_ns;
  logic [TS_W-1:0]           last_rtt_ns;
  logic [CNT_W-1:0]          sample_count;

  modport source (output valid, accepted, valid_res, offset_ns, min_rtt_offset_ns,
                  drift_ppm_q16, min_rtt_ns, last_rtt_ns, sample_count,
                  input ready);
  modport sink   (input valid, accepted, valid_res, offset_ns, min_rtt_offset_ns,
                  drift_ppm_q16, min_rtt_ns, last_rtt_ns, sample_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/codde_div.sv =====
// Restoring divider, one quotient bit per cycle, low QUO_W quotient bits only.
// Flags overflow up front when the quotient would need more bits. Uses codde_pkg.
`default_nettype none

module codde_div import codde_pkg::*; #(
  parameter int NUM_W = SCALED_W + DRIFT_FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [TS_W-1:0]  den,
  output logic                  done,
  output logic                  ovf,
  output logic [QUO_W-1:0]      quo
);

  localparam int CNT_BITS = $clog2(QUO_W);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUO_W - 1);

  logic [TS_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]    low_r;
  logic [QUO_W-1:0]    quo_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic                ovf_r;

  logic [TS_W-1:0] hi_ext;
  logic [TS_W:0]   trial;
  logic            ge;

  assign hi_ext = TS_W'(num[NUM_W-1:QUO_W]);
  assign trial  = {rem_r, low_r[QUO_W-1]};
  assign ge     = trial >= {1'b0, den};

  always_comb begin
    logic [TS_W:0] diff;
    diff    = trial - {1'b0, den};
    rem_nxt = ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (hi_ext >= den) begin
          ovf_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          ovf_r  <= 1'b0;
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi_ext;
      low_r <= num[QUO_W-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== src/codde_ctrl.sv =====
// Sequencer for the estimator: handshakes, step commands to the datapath,
// result register valid. Uses codde_pkg command and status types.
`default_nettype none

module codde_ctrl import codde_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire codde_sts_t sts,
  output codde_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_HALF  = 4'd2;
  localparam logic [3:0] ST_RAW   = 4'd3;
  localparam logic [3:0] ST_MULO  = 4'd4;
  localparam logic [3:0] ST_MULR  = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_DIFF  = 4'd8;
  localparam logic [3:0] ST_MAG   = 4'd9;
  localparam logic [3:0] ST_MLO   = 4'd10;
  localparam logic [3:0] ST_MHI   = 4'd11;
  localparam logic [3:0] ST_SCALE = 4'd12;
  localparam logic [3:0] ST_DIVS  = 4'd13;
  localparam logic [3:0] ST_DIVW  = 4'd14;
  localparam logic [3:0] ST_EMIT  = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       acc_r, acc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.emit_acc  = acc_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts.op_clear) begin
          cmd.clear = 1'b1;
          acc_nxt   = 1'b0;
          state_nxt = ST_EMIT;
        end else if (!sts.rtt_ok) begin
          acc_nxt   = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          cmd.rtt   = 1'b1;
          acc_nxt   = 1'b1;
          state_nxt = ST_HALF;
        end
      end
      ST_HALF: begin
        cmd.half  = 1'b1;
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        cmd.raw   = 1'b1;
        state_nxt = ST_MULO;
      end
      ST_MULO: begin
        cmd.mul_old = 1'b1;
        state_nxt   = ST_MULR;
      end
      ST_MULR: begin
        cmd.mul_raw = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        // drift only moves on a later sample with peer time past the origin
        state_nxt  = (sts.first || !sts.dt_pos) ? ST_EMIT : ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) begin
          cmd.drift_commit = 1'b1;
          state_nxt        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/codde_dp.sv =====
// Estimator datapath: sample registers, shared blend multiplier, estimator
// state, drift scaling and divider, result register. Uses codde_pkg, codde_div.
`default_nettype none

module codde_dp import codde_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  parameter int DRIFT_FRAC_BITS  = DRIFT_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire codde_cmd_t        cmd,
  output codde_sts_t             sts,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_op,
  input  wire logic [TS_W-1:0]   in_send,
  input  wire logic [TS_W-1:0]   in_peer,
  input  wire logic [TS_W-1:0]   in_recv,
  output logic                   res_accepted,
  output logic                   res_valid,
  output logic signed [OFS_W-1:0]   res_offset,
  output logic signed [OFS_W-1:0]   res_best_offset,
  output logic signed [DRIFT_W-1:0] res_drift,
  output logic [TS_W-1:0]        res_min_rtt,
  output logic [TS_W-1:0]        res_last_rtt,
  output logic [CNT_W-1:0]       res_count
);

  localparam int WGT_W  = (WEIGHT_FRAC_BITS + 1 > CFG_W) ? WEIGHT_FRAC_BITS + 1 : CFG_W;
  localparam int PROD_W = OFS_W + WGT_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NUM_W  = SCALED_W + DRIFT_FRAC_BITS;
  localparam int LO_W   = 33;
  localparam int HI_W   = MAG_W - LO_W;

  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1) << WEIGHT_FRAC_BITS;

  // configuration
  logic [CFG_W-1:0] cfg_weight_r;

  // captured beat
  logic            op_r;
  logic [TS_W-1:0] send_r, peer_r, recv_r;

  // per-sample working registers
  logic [TS_W-1:0]           rtt_r;
  logic [TS_W-1:0]           half_r;
  logic signed [OFS_W-1:0]   raw_r;
  logic signed [PROD_W-1:0]  prod_old_r, prod_raw_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [MAG_W-1:0]   diff_r;
  logic [TS_W-1:0]           dt_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          mag_r;
  logic [LO_W+PPM_W-1:0]     plo_r;
  logic [HI_W+PPM_W-1:0]     phi_r;
  logic [SCALED_W-1:0]       scaled_r;

  // estimator state
  logic                      have_r;
  logic signed [OFS_W-1:0]   smoothed_r;
  logic signed [OFS_W-1:0]   best_r;
  logic [TS_W-1:0]           min_rtt_r;
  logic [TS_W-1:0]           prev_rtt_r;
  logic signed [DRIFT_W-1:0] drift_r;
  logic [CNT_W-1:0]          count_r;
  logic [TS_W-1:0]           first_peer_r;
  logic signed [OFS_W-1:0]   first_ofs_r;

  // result register
  logic                      o_acc_r, o_have_r;
  logic signed [OFS_W-1:0]   o_ofs_r, o_best_r;
  logic signed [DRIFT_W-1:0] o_drift_r;
  logic [TS_W-1:0]           o_min_rtt_r, o_last_rtt_r;
  logic [CNT_W-1:0]          o_count_r;

  // weight, clamped to one
  logic [WGT_W-1:0] w_cfg, w_eff, w_rest;
  assign w_cfg  = WGT_W'(cfg_weight_r);
  assign w_eff  = (w_cfg > W_ONE) ? W_ONE : w_cfg;
  assign w_rest = W_ONE - w_eff;

  // shared blend multiplier
  logic signed [OFS_W-1:0]  mul_a;
  logic [WGT_W-1:0]         mul_b;
  logic signed [PROD_W-1:0] mul_p;
  assign mul_a = cmd.mul_raw ? raw_r : smoothed_r;
  assign mul_b = cmd.mul_raw ? w_rest : w_eff;
  assign mul_p = PROD_W'(mul_a) * $signed({1'b0, mul_b});

  // truncation toward zero: bias negative sums by one LSB below the scale
  logic signed [SUM_W-1:0] bias, biased;
  logic signed [OFS_W-1:0] blend_nxt, smoothed_nxt;
  assign bias         = sum_r[SUM_W-1] ? SUM_W'(W_ONE - 1'b1) : '0;
  assign biased       = sum_r + bias;
  assign blend_nxt    = biased[WEIGHT_FRAC_BITS +: OFS_W];
  assign smoothed_nxt = have_r ? blend_nxt : raw_r;

  // divider
  logic             div_done, div_ovf;
  logic [QUO_W-1:0] div_quo;
  logic [NUM_W-1:0] div_num;
  assign div_num = NUM_W'(scaled_r) << DRIFT_FRAC_BITS;

  codde_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (dt_r),
    .done  (div_done),
    .ovf   (div_ovf),
    .quo   (div_quo)
  );

  logic                      drift_sat;
  logic signed [DRIFT_W-1:0] drift_nxt;
  assign drift_sat = div_ovf || div_quo[QUO_W-1];
  always_comb begin
    if (neg_r) drift_nxt = drift_sat ? DRIFT_MIN : -$signed(div_quo);
    else       drift_nxt = drift_sat ? DRIFT_MAX : $signed(div_quo);
  end

  assign sts.op_clear = (op_r == OP_CLEAR);
  assign sts.rtt_ok   = recv_r >= send_r;
  assign sts.first    = !have_r;
  assign sts.dt_pos   = peer_r > first_peer_r;
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_weight_r <= CFG_WEIGHT_RESET;
    else if (cfg_we) cfg_weight_r <= cfg_wdata;
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      send_r <= in_send;
      peer_r <= in_peer;
      recv_r <= in_recv;
    end
    if (cmd.rtt)     rtt_r  <= recv_r - send_r;
    if (cmd.half)    half_r <= send_r + (rtt_r >> 1);
    if (cmd.raw)     raw_r  <= $signed({1'b0, half_r}) - $signed({1'b0, peer_r});
    if (cmd.mul_old) prod_old_r <= mul_p;
    if (cmd.mul_raw) prod_raw_r <= mul_p;
    if (cmd.sum)     sum_r <= SUM_W'(prod_old_r) + SUM_W'(prod_raw_r);
    if (cmd.diff) begin
      diff_r <= MAG_W'(smoothed_r) - MAG_W'(first_ofs_r);
      dt_r   <= peer_r - first_peer_r;
    end
    if (cmd.mag) begin
      neg_r <= diff_r[MAG_W-1];
      mag_r <= diff_r[MAG_W-1] ? MAG_W'(-diff_r) : MAG_W'(diff_r);
    end
    if (cmd.mul_lo) plo_r <= (LO_W+PPM_W)'(mag_r[LO_W-1:0]) * (LO_W+PPM_W)'(PPM_SCALE);
    if (cmd.mul_hi) phi_r <= (HI_W+PPM_W)'(mag_r[MAG_W-1:LO_W]) * (HI_W+PPM_W)'(PPM_SCALE);
    if (cmd.scale)  scaled_r <= SCALED_W'(plo_r) + SCALED_W'({phi_r, {LO_W{1'b0}}});
  end

  // estimator state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      have_r       <= 1'b0;
      smoothed_r   <= '0;
      best_r       <= '0;
      min_rtt_r    <= RTT_RESET;
      prev_rtt_r   <= '0;
      drift_r      <= '0;
      count_r      <= '0;
      first_peer_r <= '0;
      first_ofs_r  <= '0;
    end else begin
      if (cmd.update) begin
        smoothed_r <= smoothed_nxt;
        if (!have_r || rtt_r < min_rtt_r) begin
          min_rtt_r <= rtt_r;
          best_r    <= raw_r;
        end
        have_r     <= 1'b1;
        prev_rtt_r <= rtt_r;
        if (count_r != CNT_MAX) count_r <= count_r + 1'b1;
        if (!have_r) begin
          first_peer_r <= peer_r;
          first_ofs_r  <= raw_r;
        end
      end
      if (cmd.drift_commit) drift_r <= drift_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_acc_r      <= cmd.emit_acc;
      o_have_r     <= have_r;
      o_ofs_r      <= smoothed_r;
      o_best_r     <= best_r;
      o_drift_r    <= drift_r;
      o_min_rtt_r  <= have_r ? min_rtt_r : '0;
      o_last_rtt_r <= prev_rtt_r;
      o_count_r    <= count_r;
    end
  end

  assign res_accepted    = o_acc_r;
  assign res_valid       = o_have_r;
  assign res_offset      = o_ofs_r;
  assign res_best_offset = o_best_r;
  assign res_drift       = o_drift_r;
  assign res_min_rtt     = o_min_rtt_r;
  assign res_last_rtt    = o_last_rtt_r;
  assign res_count       = o_count_r;

endmodule

`default_nettype wire

// ===== src/clock_offset_drift_estimator.sv =====
// Top level of the clock offset and drift estimator: sequencer plus datapath.
// Depends on codde_pkg, codde_chan_if, codde_ctrl, codde_dp (and codde_div).
//
//  channel   dir  handshake         beat contents
//  --------  ---  ----------------  ------------------------------------------
//  in_chan   in   valid / ready     op, send/peer/recv timestamps (63b each)
//  out_chan  out  valid / ready     accepted, valid_res, offsets, drift, rtts,
//                                   sample count
//  cfg_*     in   cfg_we only       smoothing weight, Q1.WEIGHT_FRAC_BITS
//
// A clear or a discarded sample goes straight to the result; a sample without a drift
// update stops after the estimator update; a sample with a drift update also runs
// a two-pass 33x20 multiply and the 48-step restoring divider (one quotient bit per
// cycle), whose steps are skipped when it flags an out-of-range quotient up front.
// One input beat is worked at a time; in_chan.ready is high only when idle.
// The result register holds a finished beat while out_chan stalls; the next
// input beat is taken meanwhile and its result waits in the sequencer.
// Reset (rst_n low, synchronous) clears the estimator and loads weight 58982.
`default_nettype none

module clock_offset_drift_estimator import codde_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  parameter int DRIFT_FRAC_BITS  = DRIFT_FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  codde_in_if.sink              in_chan,
  codde_out_if.source           out_chan,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  codde_cmd_t cmd;
  codde_sts_t sts;

  // sequencer: owns both handshakes and the result-valid flag
  codde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: all payload, estimator state and the weight register
  codde_dp #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .DRIFT_FRAC_BITS  (DRIFT_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_chan.op),
    .in_send         (in_chan.send_time_ns),
    .in_peer         (in_chan.peer_time_ns),
    .in_recv         (in_chan.recv_time_ns),
    .res_accepted    (out_chan.accepted),
    .res_valid       (out_chan.valid_res),
    .res_offset      (out_chan.offset_ns),
    .res_best_offset (out_chan.min_rtt_offset_ns),
    .res_drift       (out_chan.drift_ppm_q16),
    .res_min_rtt     (out_chan.min_rtt_ns),
    .res_last_rtt    (out_chan.last_rtt_ns),
    .res_count       (out_chan.sample_count)
  );

endmodule

`default_nettype wire

// ===== tb/sv/codde_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the clock offset and drift estimator: tracks the estimator state
// from the sample beats, predicts every result beat and compares it field by field.
// Depends on codde_pkg and the codde_in_if / codde_out_if channel interfaces.

module codde_result_checker import codde_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  codde_in_if              in_mon,
  codde_out_if             out_mon,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatch_total,
  output int               estimates_due
);

  typedef struct {
    logic                      accepted;
    logic                      valid_res;
    logic signed [OFS_W-1:0]   offset_ns;
    logic signed [OFS_W-1:0]   best_offset_ns;
    logic signed [DRIFT_W-1:0] drift;
    logic [TS_W-1:0]           min_rtt;
    logic [TS_W-1:0]           last_rtt;
    logic [CNT_W-1:0]          count;
  } estimate_t;

  localparam int unsigned         UNITY_WEIGHT = 1 << WEIGHT_FRAC_BITS_DEF;
  localparam logic signed [127:0] WEIGHT_DIV   = 128'sd1 << WEIGHT_FRAC_BITS_DEF;
  localparam logic signed [127:0] PPM_Q        = 128'sd1000000 << DRIFT_FRAC_BITS_DEF;

  logic [CFG_W-1:0]          weight_reg;
  logic                      have_estimate;
  logic signed [OFS_W-1:0]   smooth_ofs;
  logic signed [OFS_W-1:0]   best_ofs;
  logic signed [OFS_W-1:0]   origin_ofs;
  logic signed [OFS_W-1:0]   least_rtt;
  logic [TS_W-1:0]           recent_rtt;
  logic [TS_W-1:0]           origin_peer;
  logic signed [DRIFT_W-1:0] drift_q16;
  logic [CNT_W-1:0]          sample_cnt;
  estimate_t                 pending_estimates[$];
  int                        mismatches = 0;

  task automatic clear_estimator();
    have_estimate = 1'b0;
    smooth_ofs    = '0;
    best_ofs      = '0;
    origin_ofs    = '0;
    least_rtt     = {1'b0, {(OFS_W-1){1'b1}}};
    recent_rtt    = '0;
    origin_peer   = '0;
    drift_q16     = '0;
    sample_cnt    = '0;
  endtask

  // w*old + (1-w)*raw, exact, truncated toward zero; weights above one clamp to one
  function automatic logic signed [OFS_W-1:0] blend_offset(
    input logic signed [OFS_W-1:0] old_ofs,
    input logic signed [OFS_W-1:0] raw_ofs,
    input logic [CFG_W-1:0]        w
  );
    int unsigned         w_eff;
    logic signed [127:0] old_w, raw_w, keep_w, take_w, acc;
    w_eff  = (w > UNITY_WEIGHT) ? UNITY_WEIGHT : w;
    old_w  = old_ofs;
    raw_w  = raw_ofs;
    keep_w = w_eff;
    take_w = UNITY_WEIGHT - w_eff;
    acc    = (old_w * keep_w + raw_w * take_w) / WEIGHT_DIV;
    return acc[OFS_W-1:0];
  endfunction

  // ppm drift, Q.16, truncated toward zero and clipped to 48 bits
  function automatic logic signed [DRIFT_W-1:0] drift_of_offset(
    input logic signed [OFS_W-1:0] from_ofs,
    input logic signed [OFS_W-1:0] to_ofs,
    input logic [TS_W-1:0]         span
  );
    logic signed [127:0] from_w, delta, span_w, quot;
    from_w = from_ofs;
    delta  = to_ofs;
    delta  = delta - from_w;
    span_w = span;
    quot   = (delta * PPM_Q) / span_w;
    if (quot > $signed(DRIFT_MAX)) return DRIFT_MAX;
    if (quot < $signed(DRIFT_MIN)) return DRIFT_MIN;
    return quot[DRIFT_W-1:0];
  endfunction

  task automatic apply_beat(
    input  logic            op,
    input  logic [TS_W-1:0] send,
    input  logic [TS_W-1:0] peer,
    input  logic [TS_W-1:0] recv,
    output estimate_t       res
  );
    logic signed [OFS_W-1:0] rtt, raw_ofs;
    logic                    first;
    res.accepted = 1'b0;
    if (op == OP_CLEAR) begin
      clear_estimator();
    end else if (recv >= send) begin
      rtt     = {1'b0, recv - send};
      raw_ofs = {1'b0, send} + (rtt >>> 1) - {1'b0, peer};
      first   = !have_estimate;
      res.accepted = 1'b1;
      smooth_ofs = first ? raw_ofs : blend_offset(smooth_ofs, raw_ofs, weight_reg);
      // ties keep the earlier round trip
      if (first || rtt < least_rtt) begin
        least_rtt = rtt;
        best_ofs  = raw_ofs;
      end
      have_estimate = 1'b1;
      recent_rtt    = rtt[TS_W-1:0];
      if (sample_cnt != CNT_MAX) sample_cnt++;
      if (first) begin
        origin_peer = peer;
        origin_ofs  = smooth_ofs;
      end else if (peer > origin_peer) begin
        drift_q16 = drift_of_offset(origin_ofs, smooth_ofs, peer - origin_peer);
      end
    end
    res.valid_res      = have_estimate;
    res.offset_ns      = smooth_ofs;
    res.best_offset_ns = best_ofs;
    res.drift          = drift_q16;
    res.min_rtt        = have_estimate ? least_rtt[TS_W-1:0] : '0;
    res.last_rtt       = recent_rtt;
    res.count          = sample_cnt;
  endtask

  task automatic compare_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    estimate_t want, fresh;
    if (!rst_n) begin
      weight_reg = CFG_WEIGHT_RESET;
      clear_estimator();
      pending_estimates.delete();
    end else begin
      if (cfg_we) weight_reg = cfg_wdata;
      // a result always trails its sample, so check before queuing
      if (out_mon.valid && out_mon.ready) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual offset %h",
                   $time, out_mon.offset_ns);
          mismatches++;
        end else begin
          want = pending_estimates.pop_front();
          compare_field("accepted", want.accepted, out_mon.accepted);
          compare_field("valid_res", want.valid_res, out_mon.valid_res);
          compare_field("offset_ns", want.offset_ns, out_mon.offset_ns);
          compare_field("min_rtt_offset_ns", want.best_offset_ns, out_mon.min_rtt_offset_ns);
          compare_field("drift_ppm_q16", want.drift, out_mon.drift_ppm_q16);
          compare_field("min_rtt_ns", want.min_rtt, out_mon.min_rtt_ns);
          compare_field("last_rtt_ns", want.last_rtt, out_mon.last_rtt_ns);
          compare_field("sample_count", want.count, out_mon.sample_count);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_beat(in_mon.op, in_mon.send_time_ns, in_mon.peer_time_ns,
                   in_mon.recv_time_ns, fresh);
        pending_estimates.push_back(fresh);
      end
    end
    mismatch_total <= mismatches;
    estimates_due  <= pending_estimates.size();
  end

endmodule

// ===== tb/sv/tb_clock_offset_drift_estimator.sv =====
`timescale 1ns / 1ps
// Top of the clock offset and drift estimator testbench: clock, reset, sample stimulus,
// result back-pressure and verdict. Depends on codde_pkg, the channel interfaces,
// codde_result_checker and the estimator RTL.

module tb_clock_offset_drift_estimator;
  import codde_pkg::*;

  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  typedef enum {DRAIN, COIN, SPARSE, PERIODIC} ready_style_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatch_total;
  int               estimates_due;

  // sender burst bookkeeping
  int               burst_left;

  // plausible sync stream: local clock, peer skew, origin peer stamp
  logic [TS_W-1:0]  local_t;
  logic [TS_W-1:0]  anchor_peer;
  logic signed [63:0] skew;
  bit               need_anchor;

  codde_in_if  in_bus ();
  codde_out_if out_bus ();

  clock_offset_drift_estimator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  codde_result_checker estimate_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_total (mismatch_total),
    .estimates_due  (estimates_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TS_W-1:0];
  endfunction

  // random magnitude: spreads values over every width, not just near the top
  function automatic logic [TS_W-1:0] rand_span();
    return rand_ts() >> $urandom_range(0, TS_W-1);
  endfunction

  // One sample beat. Bursts of random length, random gaps between bursts; valid stays
  // high across back-to-back beats of a burst.
  task automatic send_beat(input logic op, input logic [TS_W-1:0] send,
                           input logic [TS_W-1:0] peer, input logic [TS_W-1:0] recv);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(0, 3);
        6, 7, 8:          gap = $urandom_range(4, 20);
        default:          gap = $urandom_range(21, 90);
      endcase
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_bus.valid        <= 1'b1;
    in_bus.op           <= op;
    in_bus.send_time_ns <= send;
    in_bus.peer_time_ns <= peer;
    in_bus.recv_time_ns <= recv;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid and wait until every result beat has been drained.
  task automatic settle();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (estimates_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_weight(input logic [CFG_W-1:0] w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic restart_stream();
    logic signed [63:0] r;
    r           = {$urandom, $urandom};
    local_t     = rand_span();
    skew        = r >>> $urandom_range(20, 60);
    need_anchor = 1'b1;
  endtask

  // Well-formed ping: local time moves forward, peer skew wanders slowly,
  // round trip mostly small with the odd huge one.
  task automatic plausible_sample();
    logic [TS_W-1:0] rtt, send, peer;
    local_t = local_t + ($urandom_range(1000, 2000000) << $urandom_range(0, 10));
    skew    = skew + (int'($urandom_range(0, 2000)) - 1000);
    rtt     = ($urandom_range(0, 7) == 0) ? rand_span() : $urandom_range(0, 200000);
    send    = local_t;
    peer    = send + (rtt >> 1) - skew[TS_W-1:0] + $urandom_range(0, 1000);
    if (need_anchor) begin
      anchor_peer = peer;
      need_anchor = 1'b0;
    end
    send_beat(OP_SAMPLE, send, peer, send + rtt);
  endtask

  task automatic run_phase(input int beats);
    int              pick;
    logic [TS_W-1:0] s;
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        plausible_sample();
      end else if (pick < 76) begin
        // full-width noise, about half of it discarded
        send_beat(OP_SAMPLE, rand_ts(), rand_ts(), rand_ts());
      end else if (pick < 82) begin
        // reply stamped before the request
        s = local_t;
        send_beat(OP_SAMPLE, s, rand_ts(), s - 1 - $urandom_range(0, 5000));
      end else if (pick < 86) begin
        send_beat(OP_CLEAR, rand_ts(), rand_ts(), rand_ts());
        restart_stream();
      end else if (pick < 92) begin
        // peer time at or just behind the origin: drift must hold
        s = rand_span();
        send_beat(OP_SAMPLE, s, anchor_peer - $urandom_range(0, 1), s + $urandom_range(0, 500));
      end else begin
        // wild magnitudes, drives drift into both clip limits
        s = rand_span();
        send_beat(OP_SAMPLE, s, rand_span(), s + rand_span());
      end
    end
  endtask

  // Result back-pressure: segments of always-ready, coin-flip, sparse and
  // periodic stalls.
  initial begin
    ready_style_t style;
    int           seg_len;
    int           period;
    out_bus.ready <= 1'b0;
    forever begin
      style   = ready_style_t'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 300);
      period  = $urandom_range(1, 40);
      for (int i = 0; i < seg_len; i++) begin
        @(posedge clk);
        case (style)
          DRAIN:   out_bus.ready <= 1'b1;
          COIN:    out_bus.ready <= $urandom_range(0, 1);
          SPARSE:  out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ((i % (period + 1)) == period);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.op           <= OP_SAMPLE;
    in_bus.send_time_ns <= '0;
    in_bus.peer_time_ns <= '0;
    in_bus.recv_time_ns <= '0;
    burst_left  = 0;
    local_t     = '0;
    anchor_peer = '0;
    skew        = '0;
    need_anchor = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at the reset weight.
    send_beat(OP_CLEAR, TS_MAX, TS_MAX, TS_MAX);        // clear out of reset, all ones
    send_beat(OP_SAMPLE, TS_MAX, TS_MAX, '0);           // negative round trip, no estimate yet
    send_beat(OP_SAMPLE, '0, '0, TS_MAX);               // first sample, largest round trip
    send_beat(OP_SAMPLE, '0, '0, TS_MAX);               // equal round trip, peer at origin
    send_beat(OP_SAMPLE, TS_MAX, 63'd1, TS_MAX);        // zero rtt, dt of one: clip high
    send_beat(OP_SAMPLE, 63'd5, '0, 63'd5);             // peer back at origin
    send_beat(OP_SAMPLE, '0, TS_MAX, '0);               // most negative raw offset
    send_beat(OP_SAMPLE, 63'd100, 63'd7, 63'd99);       // discard with an estimate held
    send_beat(OP_SAMPLE, 63'd1000, 63'd3, 63'd1001);    // odd round trip, half rounds down
    send_beat(OP_CLEAR, '0, '0, '0);
    send_beat(OP_CLEAR, rand_ts(), rand_ts(), rand_ts());
    send_beat(OP_SAMPLE, TS_MAX, TS_MAX - 10, TS_MAX);  // origin near the top of peer time
    send_beat(OP_SAMPLE, '0, TS_MAX, '0);               // dt of ten, huge drop: clip low
    send_beat(OP_SAMPLE, 63'd1000, 63'd3, 63'd1000);    // peer before origin
    send_beat(OP_SAMPLE, 63'd2000, TS_MAX - 10, 63'd2000);
    send_beat(OP_CLEAR, TS_MAX, '0, TS_MAX);
    send_beat(OP_SAMPLE, '0, '0, '0);                   // all-zero first sample
    send_beat(OP_SAMPLE, '0, 63'd1, '0);

    restart_stream();
    run_phase(230);

    // Weight sweep: zero, exactly one, clamped above one, tiny, just under one, random.
    write_weight(17'd0);
    run_phase(220);
    write_weight(17'd65536);
    run_phase(220);
    write_weight(17'd131071);
    run_phase(220);
    write_weight(17'd1);
    run_phase(220);
    write_weight(17'd65535);
    run_phase(220);
    write_weight($urandom_range(0, 131071));
    run_phase(220);
    write_weight($urandom_range(40000, 65536));
    run_phase(220);

    settle();
    repeat (100) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a hung handshake never drains
  initial begin
    #25_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/codde_pkg.sv
src/codde_chan_if.sv
src/codde_div.sv
src/codde_ctrl.sv
src/codde_dp.sv
src/clock_offset_drift_estimator.sv
tb/sv/codde_result_checker.sv
tb/sv/tb_clock_offset_drift_estimator.sv
